@@ sv/polymul_pkg.sv @@
// ----------------------------------------------------------------------------
// Polynomial multiplier package
// Field widths, operation codes and the control word for the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package polymul_pkg;

  localparam int unsigned OP_W   = 1;
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned COEF_W = 16;
  localparam int unsigned DEG_W  = 6;
  localparam int unsigned PROD_W = 40;

  localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
  localparam logic [OP_W-1:0] OP_MULT = 1'b1;

  typedef struct packed {
    logic load;
    logic mac;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/polymul_cell.sv @@
// ----------------------------------------------------------------------------
// Polynomial multiplier cell
// Holds one multiplier coefficient and one running sum; hands its sum, with
// the current product added, to its left neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module polymul_cell #(
  parameter int CELL_IDX = 0
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  polymul_pkg::cell_ctrl_t               ctrl_i,
  input  wire        [polymul_pkg::IDX_W-1:0]   index_i,
  input  wire signed [polymul_pkg::COEF_W-1:0]  coef_i,
  input  wire signed [polymul_pkg::PROD_W-1:0]  next_i,
  output logic signed [polymul_pkg::PROD_W-1:0] sum_o
);
  import polymul_pkg::*;

  logic signed [COEF_W-1:0]   b_q;
  logic signed [PROD_W-1:0]   sum_q, sum_d;
  logic signed [2*COEF_W-1:0] mult_w;
  logic                       hit_w;

  assign mult_w = coef_i * b_q;
  assign sum_o  = ctrl_i.mac ? sum_q + PROD_W'(mult_w) : sum_q;
  assign sum_d  = ctrl_i.shift ? next_i : sum_q;
  assign hit_w  = ctrl_i.load && (int'(index_i) == CELL_IDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q   <= '0;
      sum_q <= '0;
    end else begin
      if (hit_w) begin
        b_q <= coef_i;
      end
      sum_q <= sum_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/polynomial_multiplier_unit.sv @@
// A multiplicand item's product coefficient is registered as it is accepted.
// Throughput: 1 item per cycle for loads and multiplicand items without last,
// unless output stalls. An item with last (or of degree TERMS-1) is followed by
// TERMS-1 more results, one per unstalled cycle as cells shift; input stalls till then.
// Reset clears the multiplier coefficients, running sums and degree counter at
// once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Polynomial multiplier unit
// Streaming convolution over a row of multiply-accumulate cells.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_multiplier_unit #(
  parameter int TERMS = 32
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire        [polymul_pkg::OP_W-1:0]    op_i,
  input  wire        [polymul_pkg::IDX_W-1:0]   index_i,
  input  wire signed [polymul_pkg::COEF_W-1:0]  coefficient_i,
  input  wire                                   last_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic       [polymul_pkg::DEG_W-1:0]   degree_o,
  output logic signed [polymul_pkg::PROD_W-1:0] product_o,
  output logic                                  final_res_o
);
  import polymul_pkg::*;

  localparam int CNT_W = $clog2(TERMS);

  logic                     out_valid_q;
  logic [DEG_W-1:0]         degree_q;
  logic signed [PROD_W-1:0] product_q;
  logic                     final_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     flush_q;
  logic [CNT_W-1:0]         rem_q;
  logic [DEG_W-1:0]         fdeg_q;

  logic       out_free_w;
  logic       accept_w;
  logic       is_mult_w;
  logic       last_eff_w;
  logic       flush_step_w;
  cell_ctrl_t ctrl_w;

  logic signed [PROD_W-1:0] chain_w [TERMS+1];

  assign out_free_w   = !out_valid_q || out_ready_i;
  assign in_ready_o   = !flush_q && out_free_w;
  assign accept_w     = in_valid_i && in_ready_o;
  assign is_mult_w    = accept_w && (op_i == OP_MULT);
  assign last_eff_w   = last_i || (cnt_q == CNT_W'(TERMS - 1));
  assign flush_step_w = flush_q && out_free_w;

  assign ctrl_w.load  = accept_w && (op_i == OP_LOAD);
  assign ctrl_w.mac   = is_mult_w;
  assign ctrl_w.shift = is_mult_w || flush_step_w;

  assign chain_w[TERMS] = '0;

  for (genvar j = 0; j < TERMS; j++) begin : g_cell
    polymul_cell #(
      .CELL_IDX(j)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_w),
      .index_i(index_i),
      .coef_i (coefficient_i),
      .next_i (chain_w[j+1]),
      .sum_o  (chain_w[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      flush_q     <= 1'b0;
      rem_q       <= '0;
      fdeg_q      <= '0;
    end else begin
      if (is_mult_w || flush_step_w) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (is_mult_w) begin
        if (last_eff_w) begin
          cnt_q   <= '0;
          flush_q <= 1'b1;
          rem_q   <= CNT_W'(TERMS - 1);
          fdeg_q  <= DEG_W'(cnt_q) + DEG_W'(1);
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end else if (flush_step_w) begin
        rem_q  <= rem_q - CNT_W'(1);
        fdeg_q <= fdeg_q + DEG_W'(1);
        if (rem_q == CNT_W'(1)) begin
          flush_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_mult_w) begin
      degree_q  <= DEG_W'(cnt_q);
      product_q <= chain_w[0];
      final_q   <= 1'b0;
    end else if (flush_step_w) begin
      degree_q  <= fdeg_q;
      product_q <= chain_w[0];
      final_q   <= (rem_q == CNT_W'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign degree_o    = degree_q;
  assign product_o   = product_q;
  assign final_res_o = final_q;

endmodule

`default_nettype wire

@@ sv/polymul_checker.sv @@
// ----------------------------------------------------------------------------
// Polynomial multiplier checker
// Port-level properties of the unit, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module polymul_checker (
  input wire                                   clk_i,
  input wire                                   rst_ni,
  input wire                                   in_ready_o,
  input wire                                   out_valid_o,
  input wire                                   out_ready_i,
  input wire        [polymul_pkg::DEG_W-1:0]   degree_o,
  input wire signed [polymul_pkg::PROD_W-1:0]  product_o,
  input wire                                   final_res_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(degree_o) && $stable(product_o) && $stable(final_res_o))
    else $error("result item changed while stalled");

  a_flush_degree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !final_res_o && !in_ready_o |=>
      out_valid_o && (degree_o == $past(degree_o) + 6'd1))
    else $error("flush did not emit the next degree");

  a_final_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && final_res_o |-> (in_ready_o == out_ready_i))
    else $error("input held off after the final item");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no result pending");

endmodule

bind polynomial_multiplier_unit polymul_checker u_polymul_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .degree_o   (degree_o),
  .product_o  (product_o),
  .final_res_o(final_res_o)
);

`default_nettype wire

@@ bench/polynomial_multiplier_unit_test.sv @@
// ----------------------------------------------------------------------------
// Polynomial multiplier unit testbench
// Loads multiplier coefficients and streams multiplicand coefficients, with
// random gaps on the input side and random stalls on the output side. Every
// product coefficient is checked in order against a convolution kept here.
// ----------------------------------------------------------------------------
module polynomial_multiplier_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import polymul_pkg::*;

  localparam int TERMS = 32;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [DEG_W-1:0]         degree;
    logic signed [PROD_W-1:0] product;
    logic                     final_res;
  } coef_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     in_valid_i    = 1'b0;
  logic                     in_ready_o;
  logic [OP_W-1:0]          op_i          = OP_LOAD;
  logic [IDX_W-1:0]         index_i       = '0;
  logic signed [COEF_W-1:0] coefficient_i = '0;
  logic                     last_i        = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i   = 1'b0;
  logic [DEG_W-1:0]         degree_o;
  logic signed [PROD_W-1:0] product_o;
  logic                     final_res_o;

  logic signed [COEF_W-1:0] mult_coef [TERMS];
  logic signed [PROD_W-1:0] run_sums [TERMS];
  logic [DEG_W-1:0]         next_degree;
  coef_t                    expected_coefs [$];

  int  mismatches = 0;
  int  cycles     = 0;
  bit  steady     = 1'b0;

  polynomial_multiplier_unit #(
    .TERMS(TERMS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .index_i      (index_i),
    .coefficient_i(coefficient_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .degree_o     (degree_o),
    .product_o    (product_o),
    .final_res_o  (final_res_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("polynomial_multiplier_unit_test: done, errors");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i = steady || ($urandom_range(0, 99) >= 13);
  end

  task automatic accumulate_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                 input logic signed [COEF_W-1:0] coef, input logic last);
    logic signed [PROD_W-1:0] a_ext;
    logic signed [PROD_W-1:0] b_ext;
    logic [DEG_W-1:0]         k;
    logic                     flush;
    coef_t                    c;
    if (op == OP_LOAD) begin
      mult_coef[idx] = coef;
      return;
    end
    k = next_degree;
    flush = last || (k >= TERMS - 1);
    a_ext = coef;
    for (int j = 0; j < TERMS; j++) begin
      b_ext = mult_coef[j];
      run_sums[j] = run_sums[j] + a_ext * b_ext;
    end
    if (!flush) begin
      c.degree = k;
      c.product = run_sums[0];
      c.final_res = 1'b0;
      expected_coefs.push_back(c);
      for (int j = 0; j < TERMS - 1; j++) run_sums[j] = run_sums[j + 1];
      run_sums[TERMS - 1] = '0;
      next_degree = k + 1'b1;
    end else begin
      for (int j = 0; j < TERMS; j++) begin
        c.degree = DEG_W'(int'(k) + j);
        c.product = run_sums[j];
        c.final_res = (j == TERMS - 1);
        expected_coefs.push_back(c);
        run_sums[j] = '0;
      end
      next_degree = '0;
    end
  endtask

  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic signed [COEF_W-1:0] coef, input logic last);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < 13) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    op_i = op;
    index_i = idx;
    coefficient_i = coef;
    last_i = last;
    do @(posedge clk_i); while (!in_ready_o);
    accumulate_item(op, idx, coef, last);
  endtask

  always @(posedge clk_i) begin
    coef_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_coefs.size() == 0) begin
        $display("%0t: unexpected result, degree %0d product %0d", $time, degree_o, product_o);
        mismatches++;
      end else begin
        want = expected_coefs.pop_front();
        if (degree_o !== want.degree) begin
          $display("%0t: degree expected %0d, got %0d", $time, want.degree, degree_o);
          mismatches++;
        end
        if (product_o !== want.product) begin
          $display("%0t: product (degree %0d) expected %0d, got %0d", $time, want.degree,
                   want.product, product_o);
          mismatches++;
        end
        if (final_res_o !== want.final_res) begin
          $display("%0t: final_res (degree %0d) expected %0b, got %0b", $time, want.degree,
                   want.final_res, final_res_o);
          mismatches++;
        end
      end
    end
  end

  function automatic logic signed [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 15))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  task automatic run_products(input int budget);
    int   sent;
    int   kind;
    int   len;
    logic broken;
    sent = 0;
    while (sent < budget) begin
      repeat ($urandom_range(0, 4)) begin
        send_item(OP_LOAD, IDX_W'($urandom), pick_coef(), 1'($urandom));
        sent++;
      end
      kind = $urandom_range(0, 9);
      len = (kind == 0) ? TERMS : $urandom_range(1, 8);
      broken = (kind == 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(OP_LOAD, IDX_W'($urandom), pick_coef(), 1'($urandom));
          sent++;
        end
        send_item(OP_MULT, IDX_W'($urandom), pick_coef(),
                  (i == len - 1) && (kind != 0) && !broken);
        sent++;
      end
    end
  endtask

  task automatic test_empty_store();
    send_item(OP_MULT, 5'd0, 16'sd1234, 1'b1);
  endtask

  task automatic test_field_extremes();
    send_item(OP_LOAD, 5'd0, 16'sh8000, 1'b1);
    send_item(OP_LOAD, 5'd31, 16'sh7fff, 1'b0);
    send_item(OP_LOAD, 5'd16, -16'sd1, 1'b0);
    send_item(OP_MULT, 5'd31, 16'sh8000, 1'b0);
    send_item(OP_MULT, 5'd0, 16'sh7fff, 1'b0);
    send_item(OP_MULT, 5'd31, -16'sd1, 1'b1);
  endtask

  task automatic test_load_during_product();
    send_item(OP_MULT, 5'd0, 16'sd3, 1'b0);
    send_item(OP_LOAD, 5'd1, 16'sh8000, 1'b0);
    send_item(OP_MULT, 5'd0, 16'sh8000, 1'b1);
  endtask

  task automatic test_full_window();
    for (int i = 0; i < TERMS; i++) send_item(OP_LOAD, IDX_W'(i), 16'sh8000, 1'b0);
    for (int i = 0; i < TERMS; i++) send_item(OP_MULT, IDX_W'(i), 16'sh8000, 1'b0);
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    run_products(16);
    steady = 1'b0;
  endtask

  task automatic test_random_products();
    run_products(24);
  endtask

  initial begin
    for (int j = 0; j < TERMS; j++) begin
      mult_coef[j] = '0;
      run_sums[j] = '0;
    end
    next_degree = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_store();
    test_field_extremes();
    test_load_during_product();
    test_full_window();
    test_back_to_back();
    test_random_products();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_coefs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("polynomial_multiplier_unit_test: done, clean");
    end else begin
      $display("polynomial_multiplier_unit_test: done, errors");
    end
    $finish;
  end

endmodule
